### design/skf_pkg.sv
// ============================================================================
// skf_pkg: shared constants and types for the scalar Kalman filter core
// Fixed-point formats, register indexes, reset values and unit widths.
// ============================================================================
package skf_pkg;

    // Default width of a sample and an estimate (signed Q16.16).
    localparam int DATA_WIDTH_DEF = 32;

    // Covariance and noise registers are unsigned Q8.24.
    localparam int COV_W = 32;
    typedef logic [COV_W-1:0] t_cov;
    localparam t_cov COV_MAX = {COV_W{1'b1}};

    // Gain is unsigned Q0.24 and may reach exactly 1.0.
    localparam int GAIN_FRAC = 24;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    typedef logic [GAIN_W-1:0] t_gain;
    localparam t_gain GAIN_ONE  = t_gain'(1) << GAIN_FRAC;
    localparam t_gain GAIN_MASK = GAIN_ONE - t_gain'(1);

    // Width of one operand slice fed to the shared multiplier.
    localparam int CHUNK_W = 16;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_PROCESS_NOISE     = t_cfg_idx'(0);
    localparam t_cfg_idx REG_MEASUREMENT_NOISE = t_cfg_idx'(1);

    // Reset values.
    localparam t_cov PROCESS_NOISE_RST     = t_cov'(16777);
    localparam t_cov MEASUREMENT_NOISE_RST = t_cov'(503316);
    localparam t_cov COVARIANCE_RST        = t_cov'(16777216);

endpackage

### design/skf_if.sv
// ============================================================================
// skf_if: request channels of the scalar Kalman filter core
// Valid/ready channels for the sample input and the estimate output.
// ============================================================================
interface skf_sample_if #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface skf_estimate_if #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
endinterface

### design/scalar_kalman_filter_core.sv
// ============================================================================
// scalar_kalman_filter_core: one-dimensional Kalman filter
// Smooths a stream of signed Q16.16 samples with a fixed-point scalar filter.
// ============================================================================
// A sample passes through the 25-step gain divider and then twice through the
// sliced multiplier; the next sample is taken only after the estimate has been
// placed in the output register and the sequencer is idle again.
// Reset (synchronous, active low) clears the estimate to zero, sets the
// covariance to 1.0 and loads the default process and measurement noise.
module scalar_kalman_filter_core #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    skf_sample_if.sink                   i_sample_ch,
    skf_estimate_if.source               o_estimate_ch,
    input  logic                         i_cfg_we,
    input  skf_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [skf_pkg::CFG_W-1:0]    i_cfg_data
);
    // The multiplier takes its operand in 16-bit slices. The operand must hold
    // both the magnitude of sample minus estimate and the covariance.
    localparam int OP_BITS = (DATA_WIDTH + 1 > skf_pkg::COV_W) ?
                             DATA_WIDTH + 1 : skf_pkg::COV_W;
    localparam int NCH     = (OP_BITS + skf_pkg::CHUNK_W - 1) / skf_pkg::CHUNK_W;
    localparam int OP_W    = NCH * skf_pkg::CHUNK_W;
    localparam int ACC_W   = OP_W + skf_pkg::GAIN_W;
    localparam int DIFF_W  = DATA_WIDTH + 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]              r_state;
    skf_pkg::t_cov           r_q;
    skf_pkg::t_cov           r_r;
    logic [DATA_WIDTH-1:0]   r_est;
    skf_pkg::t_cov           r_cov;
    logic [DATA_WIDTH-1:0]   r_sample;
    skf_pkg::t_gain          r_gain;
    logic                    r_neg;
    logic [DATA_WIDTH-1:0]   r_out;
    logic                    r_ov;

    logic                    w_accept;
    logic                    w_out_load;
    logic [skf_pkg::COV_W:0] w_den;
    logic                    w_div_done;
    skf_pkg::t_gain          w_div_quot;
    logic                    w_mac_start;
    logic                    w_mac_done;
    logic [OP_W-1:0]         w_mac_a;
    skf_pkg::t_gain          w_mac_g;
    logic [ACC_W-1:0]        w_mac_acc;
    logic [ACC_W-1:0]        w_acc_rnd;
    logic [DIFF_W-1:0]       w_diff;
    logic [DIFF_W-1:0]       w_mag;
    logic [DIFF_W-1:0]       w_q_floor;
    logic [DIFF_W-1:0]       w_q_ceil;
    logic [DIFF_W-1:0]       w_delta;
    logic [DIFF_W-1:0]       w_new_est;
    skf_pkg::t_cov           w_shrunk;
    logic [skf_pkg::COV_W:0] w_cov_sum;
    skf_pkg::t_cov           w_cov_next;

    // ------------------------------------------------------------------
    // Handshakes. The block takes a sample only while idle. A finished
    // estimate parks in the output register, so the next sample may be
    // taken while the previous estimate still waits to be read.
    // ------------------------------------------------------------------
    assign i_sample_ch.ready      = (r_state == ST_IDLE);
    assign w_accept               = i_sample_ch.valid && (r_state == ST_IDLE);
    assign o_estimate_ch.valid    = r_ov;
    assign o_estimate_ch.estimate = r_out;
    assign w_out_load             = (r_state == ST_OUT) && (!r_ov || o_estimate_ch.ready);

    // ------------------------------------------------------------------
    // Gain divider: gain = floor(P * 2^24 / (P + R)), denominator in 33 bits.
    // It starts on the same edge that accepts the sample.
    // ------------------------------------------------------------------
    assign w_den = {1'b0, r_cov} + {1'b0, r_r};

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (r_cov),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ------------------------------------------------------------------
    // Shared multiplier. First pass: gain times |sample - estimate|.
    // Second pass: (1.0 - gain) times P.
    // ------------------------------------------------------------------
    always_comb begin
        w_diff = {r_sample[DATA_WIDTH-1], r_sample} - {r_est[DATA_WIDTH-1], r_est};
        w_mag  = w_diff[DIFF_W-1] ? (DIFF_W'(0) - w_diff) : w_diff;
    end

    assign w_mac_start = ((r_state == ST_DIV) && w_div_done) ||
                         ((r_state == ST_MUL1) && w_mac_done);
    assign w_mac_a     = (r_state == ST_DIV) ? OP_W'(w_mag) : OP_W'(r_cov);
    assign w_mac_g     = (r_state == ST_DIV) ? w_div_quot : (skf_pkg::GAIN_ONE - r_gain);

    skf_mac #(
        .OP_W (OP_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_a     (w_mac_a),
        .i_g     (w_mac_g),
        .o_done  (w_mac_done),
        .o_acc   (w_mac_acc)
    );

    // ------------------------------------------------------------------
    // Estimate update. The step is the product shifted down by 24 with
    // rounding toward minus infinity: for a negative difference the
    // magnitude is rounded up before the sign is applied. The new estimate
    // lies between the old one and the sample, so it never overflows.
    // ------------------------------------------------------------------
    always_comb begin
        w_acc_rnd = w_mac_acc + ACC_W'(skf_pkg::GAIN_MASK);
        w_q_floor = w_mac_acc[skf_pkg::GAIN_FRAC +: DIFF_W];
        w_q_ceil  = w_acc_rnd[skf_pkg::GAIN_FRAC +: DIFF_W];
        w_delta   = r_neg ? (DIFF_W'(0) - w_q_ceil) : w_q_floor;
        w_new_est = {r_est[DATA_WIDTH-1], r_est} + w_delta;
    end

    // ------------------------------------------------------------------
    // Covariance update: P = floor((1 - gain) * P) + Q, saturated.
    // ------------------------------------------------------------------
    always_comb begin
        w_shrunk   = w_mac_acc[skf_pkg::GAIN_FRAC +: skf_pkg::COV_W];
        w_cov_sum  = {1'b0, w_shrunk} + {1'b0, r_q};
        w_cov_next = w_cov_sum[skf_pkg::COV_W] ? skf_pkg::COV_MAX
                                               : w_cov_sum[skf_pkg::COV_W-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer, filter state and configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_est   <= '0;
            r_cov   <= skf_pkg::COVARIANCE_RST;
            r_q     <= skf_pkg::PROCESS_NOISE_RST;
            r_r     <= skf_pkg::MEASUREMENT_NOISE_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == skf_pkg::REG_PROCESS_NOISE) begin
                    r_q <= i_cfg_data;
                end else if (i_cfg_idx == skf_pkg::REG_MEASUREMENT_NOISE) begin
                    r_r <= i_cfg_data;
                end
            end

            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_estimate_ch.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    if (w_mac_done) begin
                        r_est   <= w_new_est[DATA_WIDTH-1:0];
                        r_state <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    if (w_mac_done) begin
                        r_cov   <= w_cov_next;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Per-sample operands and the output register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample_ch.sample;
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_gain <= w_div_quot;
            r_neg  <= w_diff[DIFF_W-1];
        end
        if (w_out_load) begin
            r_out <= r_est;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_div_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && ($past(r_state) == ST_IDLE)) |->
            $past(i_sample_ch.valid))
        else $error("divider state entered without an accepted sample");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (w_div_quot <= skf_pkg::GAIN_ONE))
        else $error("gain above 1.0");

    a_mac_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> ((r_state == ST_MUL1) || (r_state == ST_MUL2)))
        else $error("multiplier finished outside a multiply state");

    a_out_slot_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && !r_ov) |=> (r_ov && (r_state == ST_IDLE)))
        else $error("free output register not filled");

endmodule

### design/skf_div.sv
// ============================================================================
// skf_div: iterative gain divider
// Restoring division giving floor(num * 2^24 / den), one quotient bit a cycle.
// ============================================================================
module skf_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  skf_pkg::t_cov        i_num,
    input  logic [skf_pkg::COV_W:0] i_den,
    output logic                 o_done,
    output skf_pkg::t_gain       o_quot
);
    localparam int REM_W = skf_pkg::COV_W + 2;
    localparam int CNT_W = $clog2(skf_pkg::GAIN_W + 1);

    logic [REM_W-1:0]          r_rem;
    logic [skf_pkg::COV_W:0]   r_den;
    skf_pkg::t_gain            r_quot;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [REM_W-1:0] w_den_ext;
    logic [REM_W-1:0] w_sub;
    logic [REM_W-1:0] w_rem_after;
    logic             w_ge;

    always_comb begin
        w_den_ext   = {1'b0, r_den};
        w_ge        = (r_rem >= w_den_ext);
        w_sub       = r_rem - w_den_ext;
        w_rem_after = w_ge ? w_sub : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(skf_pkg::GAIN_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits one bit less.
            r_rem  <= {w_rem_after[REM_W-2:0], 1'b0};
            r_quot <= {r_quot[skf_pkg::GAIN_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    // A zero divisor (zero covariance and zero noise) gives a zero gain.
    assign o_quot = (r_den == '0) ? '0 : r_quot;

endmodule

### design/skf_mac.sv
// ============================================================================
// skf_mac: sliced multiplier
// Multiplies a wide operand by a gain, one 16-bit slice a cycle, MSB first.
// ============================================================================
module skf_mac #(
    parameter int OP_W = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [OP_W-1:0]                   i_a,
    input  skf_pkg::t_gain                    i_g,
    output logic                              o_done,
    output logic [OP_W+skf_pkg::GAIN_W-1:0]   o_acc
);
    localparam int ACC_W  = OP_W + skf_pkg::GAIN_W;
    localparam int PROD_W = skf_pkg::CHUNK_W + skf_pkg::GAIN_W;
    localparam int NCH    = OP_W / skf_pkg::CHUNK_W;
    localparam int CNT_W  = $clog2(NCH + 1);

    logic [OP_W-1:0]            r_a;
    skf_pkg::t_gain             r_g;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_issue;
    logic                       r_pv;
    logic                       r_plast;
    logic                       r_done;
    logic [PROD_W-1:0]          r_prod;
    logic [ACC_W-1:0]           r_acc;

    logic [skf_pkg::CHUNK_W-1:0] w_chunk;

    assign w_chunk = r_a[OP_W-1 -: skf_pkg::CHUNK_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= r_pv && r_plast;
            if (i_start) begin
                r_issue <= 1'b1;
                r_cnt   <= CNT_W'(NCH);
                r_pv    <= 1'b0;
                r_plast <= 1'b0;
            end else if (r_issue) begin
                r_pv    <= 1'b1;
                r_plast <= (r_cnt == CNT_W'(1));
                r_issue <= (r_cnt != CNT_W'(1));
                r_cnt   <= r_cnt - CNT_W'(1);
            end else begin
                r_pv    <= 1'b0;
                r_plast <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_g   <= i_g;
            r_acc <= '0;
        end else begin
            if (r_issue) begin
                r_prod <= PROD_W'(w_chunk) * PROD_W'(r_g);
                r_a    <= r_a << skf_pkg::CHUNK_W;
            end
            if (r_pv) begin
                r_acc <= (r_acc << skf_pkg::CHUNK_W) + ACC_W'(r_prod);
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule
